// ===== sv/snfc_pkg.sv =====
// ============================================================================
// snfc_pkg
// Types and constants shared by the SPI NOR command framer modules.
// ============================================================================
`default_nettype none

package snfc_pkg;

    // Flash command bytes
    localparam logic [7:0] OP_READ             = 8'd3;
    localparam logic [7:0] OP_BYTE_PROGRAM     = 8'd2;
    localparam logic [7:0] OP_AUTO_INC_PROGRAM = 8'd173;
    localparam logic [7:0] OP_SECTOR_ERASE     = 8'd32;
    localparam logic [7:0] OP_WRITE_ENABLE     = 8'd6;
    localparam logic [7:0] OP_WRITE_DISABLE    = 8'd4;

    // Manufacturer byte that selects auto-increment word programming
    localparam logic [7:0] AAI_VENDOR = 8'hBF;

    // Request opcodes
    localparam logic [1:0] REQ_READ    = 2'd0;
    localparam logic [1:0] REQ_WRITE   = 2'd1;
    localparam logic [1:0] REQ_ERASE   = 2'd2;
    localparam logic [1:0] REQ_WR_DIS  = 2'd3;

    // Command kinds chosen by the front end
    localparam logic [2:0] KIND_READ      = 3'd0;
    localparam logic [2:0] KIND_AAI_FIRST = 3'd1;
    localparam logic [2:0] KIND_AAI_NEXT  = 3'd2;
    localparam logic [2:0] KIND_PROGRAM   = 3'd3;
    localparam logic [2:0] KIND_ERASE     = 3'd4;
    localparam logic [2:0] KIND_WR_DIS    = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [23:0] address;
        logic [15:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       frame_start;
        logic       frame_end;
        logic [1:0] rx_count;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] address;
        logic [23:0] address_inc;
        logic [15:0] write_data;
    } desc_t;

endpackage

`default_nettype wire

// ===== sv/snfc_front.sv =====
// ============================================================================
// snfc_front
// Classifies each request into a command kind and tracks the AAI armed flag.
// ============================================================================
`default_nettype none

module snfc_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [7:0]      cfg_data,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire snfc_pkg::req_t  s_req,
    input  wire logic            q_full,
    output logic                 q_push,
    output snfc_pkg::desc_t      q_desc
);

    logic [7:0] vendor_reg;
    logic       armed_reg;
    logic       armed_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign q_push    = s_valid && !q_full;

    always_comb begin
        armed_next          = armed_reg;
        q_desc.address      = s_req.address;
        q_desc.address_inc  = s_req.address + 24'd1;
        q_desc.write_data   = s_req.write_data;
        q_desc.kind         = snfc_pkg::KIND_WR_DIS;
        case (s_req.opcode)
            snfc_pkg::REQ_READ: begin
                q_desc.kind = snfc_pkg::KIND_READ;
            end
            snfc_pkg::REQ_WRITE: begin
                if (vendor_reg == snfc_pkg::AAI_VENDOR) begin
                    q_desc.kind = armed_reg ? snfc_pkg::KIND_AAI_NEXT
                                            : snfc_pkg::KIND_AAI_FIRST;
                    armed_next  = 1'b1;
                end else begin
                    q_desc.kind = snfc_pkg::KIND_PROGRAM;
                end
            end
            snfc_pkg::REQ_ERASE: begin
                q_desc.kind = snfc_pkg::KIND_ERASE;
                armed_next  = 1'b0;
            end
            default: begin
                q_desc.kind = snfc_pkg::KIND_WR_DIS;
                armed_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vendor_reg <= 8'd0;
            armed_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                vendor_reg <= cfg_data;
            end
            if (q_push) begin
                armed_reg <= armed_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/snfc_fifo.sv =====
// ============================================================================
// snfc_fifo
// Small descriptor queue between the front end and the byte sequencer.
// ============================================================================
`default_nettype none

module snfc_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire snfc_pkg::desc_t  push_desc,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output snfc_pkg::desc_t       head_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    snfc_pkg::desc_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_desc = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/snfc_back.sv =====
// ============================================================================
// snfc_back
// Byte sequencer: walks the queued command and emits one SPI byte per beat.
// ============================================================================
`default_nettype none

module snfc_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_empty,
    input  wire snfc_pkg::desc_t  q_desc,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output snfc_pkg::res_t        m_res
);

    logic [3:0]      step_reg;
    logic            valid_reg;
    snfc_pkg::res_t  res_reg;
    snfc_pkg::res_t  res_next;
    logic [3:0]      final_step;
    logic            advance;

    logic [7:0] a2, a1, a0, b2, b1, b0, d0, d1;

    assign a2 = q_desc.address[23:16];
    assign a1 = q_desc.address[15:8];
    assign a0 = q_desc.address[7:0];
    assign b2 = q_desc.address_inc[23:16];
    assign b1 = q_desc.address_inc[15:8];
    assign b0 = q_desc.address_inc[7:0];
    assign d0 = q_desc.write_data[7:0];
    assign d1 = q_desc.write_data[15:8];

    assign advance = !q_empty && (!valid_reg || m_ready);
    assign q_pop   = advance && (step_reg == final_step);
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_comb begin
        res_next.spi_byte    = 8'd0;
        res_next.frame_start = 1'b0;
        res_next.frame_end   = 1'b0;
        res_next.rx_count    = 2'd0;
        final_step           = 4'd0;
        case (q_desc.kind)
            snfc_pkg::KIND_READ: begin
                final_step = 4'd3;
                case (step_reg)
                    4'd0: begin
                        res_next.spi_byte    = snfc_pkg::OP_READ;
                        res_next.frame_start = 1'b1;
                    end
                    4'd1: res_next.spi_byte = a2;
                    4'd2: res_next.spi_byte = a1;
                    default: begin
                        res_next.spi_byte  = a0;
                        res_next.frame_end = 1'b1;
                        res_next.rx_count  = 2'd2;
                    end
                endcase
            end
            snfc_pkg::KIND_AAI_FIRST: begin
                final_step = 4'd6;
                case (step_reg)
                    4'd0: begin
                        res_next.spi_byte    = snfc_pkg::OP_WRITE_ENABLE;
                        res_next.frame_start = 1'b1;
                        res_next.frame_end   = 1'b1;
                    end
                    4'd1: begin
                        res_next.spi_byte    = snfc_pkg::OP_AUTO_INC_PROGRAM;
                        res_next.frame_start = 1'b1;
                    end
                    4'd2: res_next.spi_byte = a2;
                    4'd3: res_next.spi_byte = a1;
                    4'd4: res_next.spi_byte = a0;
                    4'd5: res_next.spi_byte = d0;
                    default: begin
                        res_next.spi_byte  = d1;
                        res_next.frame_end = 1'b1;
                    end
                endcase
            end
            snfc_pkg::KIND_AAI_NEXT: begin
                final_step = 4'd2;
                case (step_reg)
                    4'd0: begin
                        res_next.spi_byte    = snfc_pkg::OP_AUTO_INC_PROGRAM;
                        res_next.frame_start = 1'b1;
                    end
                    4'd1: res_next.spi_byte = d0;
                    default: begin
                        res_next.spi_byte  = d1;
                        res_next.frame_end = 1'b1;
                    end
                endcase
            end
            snfc_pkg::KIND_PROGRAM: begin
                final_step = 4'd11;
                case (step_reg)
                    4'd0, 4'd6: begin
                        res_next.spi_byte    = snfc_pkg::OP_WRITE_ENABLE;
                        res_next.frame_start = 1'b1;
                        res_next.frame_end   = 1'b1;
                    end
                    4'd1, 4'd7: begin
                        res_next.spi_byte    = snfc_pkg::OP_BYTE_PROGRAM;
                        res_next.frame_start = 1'b1;
                    end
                    4'd2: res_next.spi_byte = a2;
                    4'd3: res_next.spi_byte = a1;
                    4'd4: res_next.spi_byte = a0;
                    4'd5: begin
                        res_next.spi_byte  = d0;
                        res_next.frame_end = 1'b1;
                    end
                    4'd8:  res_next.spi_byte = b2;
                    4'd9:  res_next.spi_byte = b1;
                    4'd10: res_next.spi_byte = b0;
                    default: begin
                        res_next.spi_byte  = d1;
                        res_next.frame_end = 1'b1;
                    end
                endcase
            end
            snfc_pkg::KIND_ERASE: begin
                final_step = 4'd5;
                case (step_reg)
                    4'd0: begin
                        res_next.spi_byte    = snfc_pkg::OP_WRITE_ENABLE;
                        res_next.frame_start = 1'b1;
                        res_next.frame_end   = 1'b1;
                    end
                    4'd1: begin
                        res_next.spi_byte    = snfc_pkg::OP_SECTOR_ERASE;
                        res_next.frame_start = 1'b1;
                    end
                    4'd2: res_next.spi_byte = a2;
                    4'd3: res_next.spi_byte = a1;
                    4'd4: begin
                        res_next.spi_byte  = a0;
                        res_next.frame_end = 1'b1;
                    end
                    default: begin
                        res_next.spi_byte    = snfc_pkg::OP_WRITE_DISABLE;
                        res_next.frame_start = 1'b1;
                        res_next.frame_end   = 1'b1;
                    end
                endcase
            end
            default: begin
                final_step           = 4'd0;
                res_next.spi_byte    = snfc_pkg::OP_WRITE_DISABLE;
                res_next.frame_start = 1'b1;
                res_next.frame_end   = 1'b1;
            end
        endcase
        res_next.last = (step_reg == final_step);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= 4'd0;
        end else begin
            if (advance) begin
                valid_reg <= 1'b1;
                step_reg  <= q_pop ? 4'd0 : step_reg + 4'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/spi_nor_command_framer.sv =====
// ============================================================================
// spi_nor_command_framer
// Turns flash requests into SPI command bytes grouped into chip-select frames.
// ============================================================================
// Each request (read word, write word, erase sector, write disable) becomes
// 1 to 12 result beats, one SPI byte per beat, with frame_start/frame_end
// marking chip select and last marking the request's final byte. The front
// end classifies a request on acceptance, tracks the AAI armed flag and pushes
// a descriptor into a queue of QUEUE_DEPTH entries; it takes a new request in
// any cycle the queue has room. The back end's byte counter emits one beat per
// cycle while m_ready is high and the queue is not empty, moving straight from
// one request to the next, so a request gives one beat per byte:
// 4 for a read, 7 or 3 for an AAI write, 12 for a byte-program write, 6 for
// an erase and 1 for write disable. Write vendor_id only while idle.
// ============================================================================
`default_nettype none

module spi_nor_command_framer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // configuration: vendor_id
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [7:0]      cfg_data,
    // request channel
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire snfc_pkg::req_t  s_req,
    // SPI byte channel
    output logic                 m_valid,
    input  wire logic            m_ready,
    output snfc_pkg::res_t       m_res
);

    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    snfc_pkg::desc_t push_desc;
    snfc_pkg::desc_t head_desc;

    // Classify the request and hold the armed flag
    snfc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_desc    (push_desc)
    );

    // Decouple acceptance from byte emission
    snfc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_desc (head_desc)
    );

    // Advance through the command bytes, one beat per cycle while m_ready is high and the queue is not empty
    snfc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_desc  (head_desc),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

endmodule

`default_nettype wire

// ===== tb/spi_nor_command_framer_tb.sv =====
// ============================================================================
// spi_nor_command_framer_tb
// Self-checking bench for the SPI NOR command framer.
// ============================================================================
// The bench sends flash requests on the s_ channel and collects SPI byte beats
// on the m_ channel, with random gaps and stalls on both sides. A small
// scoreboard class keeps its own copy of vendor_id and the AAI armed flag,
// works out the beats that each accepted request must produce, and checks
// every output beat field by field against the oldest one still outstanding.
// A short directed part walks the field extremes, every opcode, the address
// wrap on the second programmed byte and the AAI armed flag across vendor
// changes. A random part then runs several vendor settings back to back.
// ============================================================================

module spi_nor_command_framer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------------
    // Scoreboard: predict SPI beats per request and check them in order
    // ------------------------------------------------------------------------
    class spi_frame_scoreboard;
        logic [7:0]      vendor_id;
        bit              aai_armed;
        snfc_pkg::res_t  pending_beats[$];
        int              errors;
        int              beats_checked;
        int              n_read, n_aai_first, n_aai_next, n_program, n_erase, n_wr_dis;

        function new();
            vendor_id     = 8'h00;
            aai_armed     = 1'b0;
            errors        = 0;
            beats_checked = 0;
            n_read        = 0;
            n_aai_first   = 0;
            n_aai_next    = 0;
            n_program     = 0;
            n_erase       = 0;
            n_wr_dis      = 0;
        endfunction

        function void add_beat(logic [7:0] b, logic fs, logic fe, logic [1:0] rx);
            snfc_pkg::res_t e;
            e.spi_byte    = b;
            e.frame_start = fs;
            e.frame_end   = fe;
            e.rx_count    = rx;
            e.last        = 1'b0;
            pending_beats.push_back(e);
        endfunction

        // Address goes out high byte first
        function void add_address(logic [23:0] a);
            add_beat(a[23:16], 1'b0, 1'b0, 2'd0);
            add_beat(a[15:8],  1'b0, 1'b0, 2'd0);
        endfunction

        // One write-enable frame plus one byte-program frame
        function void add_program(logic [23:0] a, logic [7:0] d);
            add_beat(snfc_pkg::OP_WRITE_ENABLE, 1'b1, 1'b1, 2'd0);
            add_beat(snfc_pkg::OP_BYTE_PROGRAM, 1'b1, 1'b0, 2'd0);
            add_address(a);
            add_beat(a[7:0], 1'b0, 1'b0, 2'd0);
            add_beat(d, 1'b0, 1'b1, 2'd0);
        endfunction

        function void predict_frames(snfc_pkg::req_t r);
            case (r.opcode)
                snfc_pkg::REQ_READ: begin
                    n_read++;
                    add_beat(snfc_pkg::OP_READ, 1'b1, 1'b0, 2'd0);
                    add_address(r.address);
                    add_beat(r.address[7:0], 1'b0, 1'b1, 2'd2);
                end
                snfc_pkg::REQ_WRITE: begin
                    if (vendor_id == snfc_pkg::AAI_VENDOR && !aai_armed) begin
                        n_aai_first++;
                        add_beat(snfc_pkg::OP_WRITE_ENABLE, 1'b1, 1'b1, 2'd0);
                        add_beat(snfc_pkg::OP_AUTO_INC_PROGRAM, 1'b1, 1'b0, 2'd0);
                        add_address(r.address);
                        add_beat(r.address[7:0], 1'b0, 1'b0, 2'd0);
                        add_beat(r.write_data[7:0], 1'b0, 1'b0, 2'd0);
                        add_beat(r.write_data[15:8], 1'b0, 1'b1, 2'd0);
                        aai_armed = 1'b1;
                    end else if (vendor_id == snfc_pkg::AAI_VENDOR) begin
                        n_aai_next++;
                        add_beat(snfc_pkg::OP_AUTO_INC_PROGRAM, 1'b1, 1'b0, 2'd0);
                        add_beat(r.write_data[7:0], 1'b0, 1'b0, 2'd0);
                        add_beat(r.write_data[15:8], 1'b0, 1'b1, 2'd0);
                    end else begin
                        n_program++;
                        add_program(r.address, r.write_data[7:0]);
                        add_program(r.address + 24'd1, r.write_data[15:8]);
                    end
                end
                snfc_pkg::REQ_ERASE: begin
                    n_erase++;
                    add_beat(snfc_pkg::OP_WRITE_ENABLE, 1'b1, 1'b1, 2'd0);
                    add_beat(snfc_pkg::OP_SECTOR_ERASE, 1'b1, 1'b0, 2'd0);
                    add_address(r.address);
                    add_beat(r.address[7:0], 1'b0, 1'b1, 2'd0);
                    add_beat(snfc_pkg::OP_WRITE_DISABLE, 1'b1, 1'b1, 2'd0);
                    aai_armed = 1'b0;
                end
                default: begin
                    n_wr_dis++;
                    add_beat(snfc_pkg::OP_WRITE_DISABLE, 1'b1, 1'b1, 2'd0);
                    aai_armed = 1'b0;
                end
            endcase
            pending_beats[pending_beats.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(snfc_pkg::res_t got);
            snfc_pkg::res_t want;
            if (pending_beats.size() == 0) begin
                $error("SPI beat %0h arrived with no beat outstanding", got.spi_byte);
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            beats_checked++;
            compare_field("spi_byte",    want.spi_byte,        got.spi_byte);
            compare_field("frame_start", 8'(want.frame_start), 8'(got.frame_start));
            compare_field("frame_end",   8'(want.frame_end),   8'(got.frame_end));
            compare_field("rx_count",    8'(want.rx_count),    8'(got.rx_count));
            compare_field("last",        8'(want.last),        8'(got.last));
        endfunction

        function int outstanding();
            return pending_beats.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block hookup
    // ------------------------------------------------------------------------
    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [7:0]      cfg_data  = 8'h00;
    logic            s_valid   = 1'b0;
    logic            s_ready;
    snfc_pkg::req_t  s_req     = '0;
    logic            m_valid;
    logic            m_ready   = 1'b0;
    snfc_pkg::res_t  m_res;

    // Toggle per phase: when set, neither side idles
    bit         quiet      = 1'b0;
    int         stall_left = 0;
    int         vendor_writes = 0;

    spi_frame_scoreboard beat_board;

    always #6 aclk = ~aclk;

    spi_nor_command_framer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    // ------------------------------------------------------------------------
    // Result side: stall m_ready at random, check every beat that moves
    // ------------------------------------------------------------------------
    // Mostly short stalls, now and then a long one; none during quiet phases.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                          : $urandom_range(1, 3);
            end
        end
    end

    // Sample at the edge: valid, ready and payload all hold their pre-edge values
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beat_board.check_beat(m_res);
        end
    end

    // ------------------------------------------------------------------------
    // Request side helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [23:0] pick_address();
        case ($urandom_range(0, 9))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'hFFFFFF - 24'($urandom_range(0, 3));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_data();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Writes dominate so that AAI runs build up between erases and disables
    function automatic logic [1:0] pick_opcode();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return snfc_pkg::REQ_WRITE;
        if (roll < 65) return snfc_pkg::REQ_READ;
        if (roll < 82) return snfc_pkg::REQ_ERASE;
        return snfc_pkg::REQ_WR_DIS;
    endfunction

    // Present one request beat and hold it until accepted. Drop valid only
    // when a gap follows, so valid is never lowered and raised in one step.
    task automatic send_request(input logic [1:0] op, input logic [23:0] a,
                                input logic [15:0] d);
        int             gap;
        snfc_pkg::req_t r;
        gap          = pick_gap();
        r.opcode     = op;
        r.address    = a;
        r.write_data = d;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
        beat_board.predict_frames(r);
    endtask

    // Stop sending and wait until every predicted beat has come out
    task automatic drain_frames();
        s_valid <= 1'b0;
        while (beat_board.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write vendor_id; only called while the block is idle
    task automatic write_vendor(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        beat_board.vendor_id = v;
        vendor_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] vendor_plan [8];

        beat_board = new();
        vendor_plan = '{8'hBF, 8'h00, 8'hBF, 8'hFF, 8'hBE, 8'hBF, 8'hC0, 8'hBF};
        vendor_plan[6] = 8'($urandom_range(0, 255));

        // Hold reset low, then release
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Plain vendor: reads at the address extremes, byte-program writes
        // including the second-byte address wrap, erase and write disable
        write_vendor(8'h00);
        send_request(snfc_pkg::REQ_READ,   24'h000000, 16'h0000);
        send_request(snfc_pkg::REQ_READ,   24'hFFFFFF, 16'hFFFF);
        send_request(snfc_pkg::REQ_WRITE,  24'hFFFFFF, 16'hFFFF);
        send_request(snfc_pkg::REQ_WRITE,  24'h000000, 16'h0000);
        send_request(snfc_pkg::REQ_ERASE,  24'hABCDEF, 16'h1234);
        send_request(snfc_pkg::REQ_WR_DIS, 24'h5A5A5A, 16'hA5A5);
        drain_frames();

        // AAI vendor: arm on the first write, stay armed across a read,
        // disarm on erase and on write disable
        write_vendor(snfc_pkg::AAI_VENDOR);
        send_request(snfc_pkg::REQ_WRITE,  24'h123456, 16'hA55A);
        send_request(snfc_pkg::REQ_WRITE,  24'h000000, 16'h00FF);
        send_request(snfc_pkg::REQ_READ,   24'h800000, 16'h0000);
        send_request(snfc_pkg::REQ_WRITE,  24'hFFFFFF, 16'hFF00);
        send_request(snfc_pkg::REQ_ERASE,  24'h00F000, 16'h0000);
        send_request(snfc_pkg::REQ_WRITE,  24'hFFFFFE, 16'h8001);
        send_request(snfc_pkg::REQ_WR_DIS, 24'h000000, 16'h0000);
        send_request(snfc_pkg::REQ_WRITE,  24'h7FFFFF, 16'h7FFE);
        send_request(snfc_pkg::REQ_WRITE,  24'h000001, 16'hFFFF);
        drain_frames();

        // Vendor change while armed: writes under another vendor keep the flag
        write_vendor(8'hFF);
        send_request(snfc_pkg::REQ_WRITE,  24'hFFFFFF, 16'h5AA5);
        send_request(snfc_pkg::REQ_READ,   24'h010203, 16'h0000);
        drain_frames();
        write_vendor(snfc_pkg::AAI_VENDOR);
        send_request(snfc_pkg::REQ_WRITE,  24'h333333, 16'hC3C3);
        drain_frames();

        // Erase under another vendor still disarms
        write_vendor(8'h00);
        send_request(snfc_pkg::REQ_ERASE,  24'hFFFFFF, 16'hFFFF);
        drain_frames();
        write_vendor(snfc_pkg::AAI_VENDOR);
        send_request(snfc_pkg::REQ_WRITE,  24'h444444, 16'h0001);
        send_request(snfc_pkg::REQ_WR_DIS, 24'hFFFFFF, 16'hFFFF);
        drain_frames();

        // Random phases, one vendor setting each; one phase runs without
        // any idling, others at random
        for (int phase = 0; phase < 8; phase++) begin
            write_vendor(vendor_plan[phase]);
            quiet = (phase == 2) || ($urandom_range(0, 4) == 0);
            for (int k = 0; k < 35; k++) begin
                // Pause mid-phase once until the output has fully drained
                if (phase == 3 && k == 17) drain_frames();
                send_request(pick_opcode(), pick_address(), pick_data());
            end
            drain_frames();
        end
        quiet = 1'b0;

        // Let any stray beat show up before judging
        repeat (16) @(posedge aclk);

        $display("Checked %0d SPI beats over %0d vendor writes: %0d reads, %0d AAI first,",
                 beat_board.beats_checked, vendor_writes, beat_board.n_read,
                 beat_board.n_aai_first);
        $display("  %0d AAI follow-on, %0d byte-program, %0d erase, %0d write-disable requests.",
                 beat_board.n_aai_next, beat_board.n_program, beat_board.n_erase,
                 beat_board.n_wr_dis);
        if (beat_board.errors == 0 && beat_board.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog: far beyond the slowest legal run
    // ------------------------------------------------------------------------
    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
sv/snfc_pkg.sv
sv/snfc_front.sv
sv/snfc_fifo.sv
sv/snfc_back.sv
sv/spi_nor_command_framer.sv
tb/spi_nor_command_framer_tb.sv
